[hdl/msss_pkg.sv]
// Package for the multiplexed seven-segment scanner: payload and config types,
// decoder codes, on-time tables and glyph tables. No dependencies.
package msss_pkg;

   // Fixed geometry of one digit group.
   localparam int DIGITS_PER_GROUP = 4;
   localparam int POS_WIDTH        = $clog2(DIGITS_PER_GROUP);

   // Digit codes and limits.
   localparam logic [3:0]  BLANK_DIGIT  = 4'd10;
   localparam logic [3:0]  INHIBIT_CODE = 4'h8;
   localparam logic [13:0] VALUE_MAX    = 14'd9999;

   // Operation codes of a request.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Register indexes of the configuration port.
   localparam int         CSR_INDEX_WIDTH  = 1;
   localparam logic [0:0] CSR_BRIGHTNESS   = 1'b0;
   localparam logic [0:0] CSR_FRAME_PERIOD = 1'b1;

   // Register reset values.
   localparam logic [2:0]  BRIGHTNESS_RESET   = 3'd4;
   localparam logic [15:0] FRAME_PERIOD_RESET = 16'd10000;

   typedef logic [DIGITS_PER_GROUP-1:0][3:0] digit_group_type;

   typedef struct packed {
      logic        operation;
      logic [13:0] primary_value;
      logic [13:0] secondary_value;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] digit_code;
      logic [6:0] segments;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  brightness_level;
      logic [15:0] frame_period_us;
   } cfg_type;

   // On-time per digit and its multiples, indexed by brightness level.
   localparam logic [14:0] ON_X1 [8] = '{15'd1, 15'd5, 15'd50, 15'd200,
                                         15'd500, 15'd1000, 15'd2000, 15'd5000};
   localparam logic [14:0] ON_X2 [8] = '{15'd2, 15'd10, 15'd100, 15'd400,
                                         15'd1000, 15'd2000, 15'd4000, 15'd10000};
   localparam logic [14:0] ON_X3 [8] = '{15'd3, 15'd15, 15'd150, 15'd600,
                                         15'd1500, 15'd3000, 15'd6000, 15'd15000};
   localparam logic [14:0] ON_X4 [8] = '{15'd4, 15'd20, 15'd200, 15'd800,
                                         15'd2000, 15'd4000, 15'd8000, 15'd20000};

   // Decoder select codes for each position of the two groups.
   localparam logic [3:0] CODE_FIRST  [DIGITS_PER_GROUP] = '{4'h5, 4'h7, 4'h3, 4'h1};
   localparam logic [3:0] CODE_SECOND [DIGITS_PER_GROUP] = '{4'h6, 4'h0, 4'h4, 4'h2};

   // Segment patterns, bit 6 = A down to bit 0 = G; codes above nine are dark.
   localparam logic [6:0] GLYPH_UPRIGHT [16] = '{
      7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
   localparam logic [6:0] GLYPH_FLIPPED [16] = '{
      7'h7E, 7'h06, 7'h6D, 7'h4F, 7'h17, 7'h5B, 7'h7B, 7'h0E, 7'h7F, 7'h5F,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00};

endpackage

[hdl/msss_digit_conv.sv]
// Binary to right-aligned decimal digits with leading blanks for one group.
// Depends on msss_pkg.
module msss_digit_conv
   import msss_pkg::*;
(
   input  logic [13:0]     value,
   output digit_group_type digits
);

   logic [13:0] sat_value;
   logic [30:0] prod_10;
   logic [30:0] prod_100;
   logic [30:0] prod_1000;
   logic [9:0]  quot_10;
   logic [6:0]  quot_100;
   logic [3:0]  quot_1000;

   // Saturate to four decimal digits.
   assign sat_value = (value > VALUE_MAX) ? VALUE_MAX : value;

   // Division by constants through reciprocal multiplication; exact over the saturated range 0..9999.
   assign prod_10   = 31'(sat_value) * 31'd6554;
   assign prod_100  = 31'(sat_value) * 31'd5243;
   assign prod_1000 = 31'(sat_value) * 31'd8389;
   assign quot_10   = prod_10[25:16];
   assign quot_100  = prod_100[25:19];
   assign quot_1000 = prod_1000[26:23];

   // Each digit is a quotient minus ten times the next quotient.
   // A leading position blanks when it and every position left of it are zero.
   always_comb begin
      digits[3] = 4'(sat_value - 14'(quot_10) * 14'd10);
      digits[2] = (quot_10 == 10'd0) ? BLANK_DIGIT : 4'(quot_10 - 10'(quot_100) * 10'd10);
      digits[1] = (quot_100 == 7'd0) ? BLANK_DIGIT : 4'(quot_100 - 7'(quot_1000) * 7'd10);
      digits[0] = (quot_1000 == 4'd0) ? BLANK_DIGIT : quot_1000;
   end

endmodule

[hdl/msss_scan_core.sv]
// Display state (digit sets, group, frame counter) and the per-request scan logic.
// Depends on msss_pkg and msss_digit_conv.
module msss_scan_core
   import msss_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  req_payload_type item,
   input  cfg_type         cfg,
   output rsp_payload_type result
);

   digit_group_type first_digits_ff, first_digits_in;
   digit_group_type second_digits_ff, second_digits_in;
   logic            group_ff, group_in;
   logic [15:0]     count_ff, count_in;

   digit_group_type   first_conv;
   digit_group_type   second_conv;
   logic [14:0]       on_x1, on_x2, on_x3, lit_span;
   logic [15:0]       frame_len;
   logic [16:0]       next_count;
   logic              frame_end;
   logic              lit_phase;
   logic [POS_WIDTH-1:0] pos;
   logic [3:0]        digit;
   logic              is_load;

   msss_digit_conv u_conv_first  (.value(item.primary_value),   .digits(first_conv));
   msss_digit_conv u_conv_second (.value(item.secondary_value), .digits(second_conv));

   assign is_load = (item.operation == OP_LOAD);

   // Timing thresholds for the current brightness.
   assign on_x1     = ON_X1[cfg.brightness_level];
   assign on_x2     = ON_X2[cfg.brightness_level];
   assign on_x3     = ON_X3[cfg.brightness_level];
   assign lit_span  = ON_X4[cfg.brightness_level];
   assign frame_len = (cfg.frame_period_us < 16'(lit_span)) ? 16'(lit_span)
                                                           : cfg.frame_period_us;
   assign lit_phase = (count_ff < 16'(lit_span));
   assign next_count = 17'(count_ff) + 17'd1;
   assign frame_end  = (next_count >= 17'(frame_len));

   // Position within the lit span by comparing against the on-time multiples.
   always_comb begin
      if (count_ff >= 16'(on_x3)) begin
         pos = 2'd3;
      end else if (count_ff >= 16'(on_x2)) begin
         pos = 2'd2;
      end else if (count_ff >= 16'(on_x1)) begin
         pos = 2'd1;
      end else begin
         pos = 2'd0;
      end
   end

   assign digit = group_ff ? second_digits_ff[pos] : first_digits_ff[pos];

   // Result: inhibit on loads and in the blank tail of the frame.
   always_comb begin
      result.digit_code = INHIBIT_CODE;
      result.segments   = 7'd0;
      if (!is_load && lit_phase) begin
         if (group_ff) begin
            result.digit_code = CODE_SECOND[pos];
            result.segments   = GLYPH_UPRIGHT[digit];
         end else begin
            result.digit_code = CODE_FIRST[pos];
            // The right half of the first group is mounted upside down.
            result.segments   = pos[1] ? GLYPH_FLIPPED[digit] : GLYPH_UPRIGHT[digit];
         end
      end
   end

   // Next state: loads replace the digits, ticks move the frame.
   always_comb begin
      first_digits_in  = first_digits_ff;
      second_digits_in = second_digits_ff;
      group_in         = group_ff;
      count_in         = count_ff;
      if (advance) begin
         if (is_load) begin
            first_digits_in  = first_conv;
            second_digits_in = second_conv;
         end else if (frame_end) begin
            count_in = 16'd0;
            group_in = ~group_ff;
         end else begin
            count_in = next_count[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_digits_ff  <= {DIGITS_PER_GROUP{BLANK_DIGIT}};
         second_digits_ff <= {DIGITS_PER_GROUP{BLANK_DIGIT}};
         group_ff         <= 1'b0;
         count_ff         <= 16'd0;
      end else begin
         first_digits_ff  <= first_digits_in;
         second_digits_ff <= second_digits_in;
         group_ff         <= group_in;
         count_ff         <= count_in;
      end
   end

endmodule

[hdl/multiplexed_seven_segment_scanner_unit.sv]
// Pipeline: the request is held in the input register, then its result in the result
// register; a stalled response holds the result, and then the request, in place.
// Throughput: one request per cycle unless the response stalls; scan logic is combinational.
// Reset (synchronous, active high): all digits blank, first group, frame counter zero,
// brightness level 4, frame period 10000 ticks, both pipeline registers empty.
// Depends on msss_pkg and msss_scan_core.
module multiplexed_seven_segment_scanner_unit
   import msss_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                csr_wdata
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff, in_item_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff, out_item_in;
   cfg_type         cfg_ff, cfg_in;
   rsp_payload_type core_result;
   logic            advance;
   logic            req_take;

   // Pipeline handshake: the held request moves on when the result register frees up.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in   = req_take ? req_payload : in_item_ff;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);
      out_item_in  = advance ? core_result : out_item_ff;
   end

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BRIGHTNESS:   cfg_in.brightness_level = csr_wdata[2:0];
            CSR_FRAME_PERIOD: cfg_in.frame_period_us  = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   msss_scan_core u_core (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         cfg_ff.brightness_level <= BRIGHTNESS_RESET;
         cfg_ff.frame_period_us  <= FRAME_PERIOD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   // A request that leaves the input register always shows up as a result.
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid)
      else $error("advanced request did not reach the result register");

   // A held request is never dropped while blocked.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("blocked request lost from the input register");

   // The inhibit code never carries lit segments.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.digit_code == INHIBIT_CODE) |-> (rsp_payload.segments == 7'd0))
      else $error("segments lit while inhibited");

   // Only select codes 0..7 or the inhibit code are ever driven.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.digit_code[3]) |-> (rsp_payload.digit_code == INHIBIT_CODE))
      else $error("invalid digit decoder code");

endmodule
